[rtl/lru_pkg.sv]
package lru_pkg;

  localparam int ENTRIES_DEF    = 8;
  localparam int TAG_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int          CAP_BITS  = 4;
  localparam logic [3:0]  CAP_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_LOADED   = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

endpackage

[rtl/lru_cache_lookup_fill_top.sv]
// flow: a request accepted in IDLE passes the SCAN, DRAIN and UPDATE states;
//   no new request is taken until its result is issued; the tag scan reads one
//   entry per cycle through the single read port of the entry memory
// reset: synchronous, clears valid marks, recency ranks and occupancy and sets
//   capacity to 8; the entry memory is not cleared and needs no sweep
module lru_cache_lookup_fill_top #(
  parameter int ENTRIES    = lru_pkg::ENTRIES_DEF,
  parameter int TAG_BITS   = lru_pkg::TAG_BITS_DEF,
  parameter int VALUE_BITS = lru_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lru_pkg::CAP_BITS-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [TAG_BITS-1:0]         key_tag,
  input  logic [VALUE_BITS-1:0]       fill_value,
  input  logic                        fill_found,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [VALUE_BITS-1:0]       value_out,
  output logic                        evicted,
  output logic [TAG_BITS-1:0]         evicted_key
);
  import lru_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CW     = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;
  localparam int WORD_W = TAG_BITS + VALUE_BITS;

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, UPDATE} state_t;

  state_t state;

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_word;

  logic [ENTRIES-1:0] valid;
  logic [RANK_W-1:0]  rank [ENTRIES];
  logic [OCC_W-1:0]   occ;
  logic [CAP_BITS-1:0] capacity;

  logic [TAG_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] fill;
  logic                  found;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_en;

  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [VALUE_BITS-1:0] hit_data;
  logic                  vic_found;
  logic [IDX_W-1:0]      vic_idx;
  logic [TAG_BITS-1:0]   vic_tag;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  logic [TAG_BITS-1:0]   rd_tag;
  logic [VALUE_BITS-1:0] rd_data;
  logic [OCC_W-1:0]      occ_m1;
  logic [CW-1:0]         eff_cap;
  logic                  do_evict;
  logic                  do_ins;
  logic [IDX_W-1:0]      slot;
  logic                  upd_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign rd_tag    = rd_word[WORD_W-1:VALUE_BITS];
  assign rd_data   = rd_word[VALUE_BITS-1:0];
  assign occ_m1    = occ - 1'b1;
  assign upd_fire  = (state == UPDATE) && (!out_valid || out_ready);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(capacity) > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  always_comb begin
    do_evict = !hit && found && (CW'(occ) >= eff_cap) && vic_found;
    do_ins   = 1'b0;
    slot     = free_idx;
    if (!hit && found) begin
      if (do_evict) begin
        do_ins = 1'b1;
        slot   = (free_found && (free_idx < vic_idx)) ? free_idx : vic_idx;
      end else begin
        do_ins = free_found;
      end
    end
  end

  // entry memory: one read port for the scan, one write port for the fill
  always_ff @(posedge clk) begin
    rd_word <= mem[scan_idx];
    if (upd_fire && do_ins) begin
      mem[slot] <= {key, fill};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
      occ       <= '0;
      capacity  <= CAP_RESET;
      cmp_en    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // compare stage, one entry behind the read address
      if (cmp_en) begin
        if (!hit && valid[cmp_idx] && (rd_tag == key)) begin
          hit      <= 1'b1;
          hit_idx  <= cmp_idx;
          hit_rank <= rank[cmp_idx];
          hit_data <= rd_data;
        end
        if (valid[cmp_idx] && (occ != '0) && (rank[cmp_idx] == occ_m1[RANK_W-1:0])) begin
          vic_found <= 1'b1;
          vic_idx   <= cmp_idx;
          vic_tag   <= rd_tag;
        end
        if (!free_found && !valid[cmp_idx]) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end

      case (state)
        IDLE: begin
          if (in_valid) begin
            key        <= key_tag;
            fill       <= fill_value;
            found      <= fill_found;
            scan_idx   <= '0;
            cmp_en     <= 1'b0;
            hit        <= 1'b0;
            vic_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          cmp_idx <= scan_idx;
          cmp_en  <= 1'b1;
          if (scan_idx == IDX_W'(ENTRIES - 1)) begin
            state <= DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        DRAIN: begin
          cmp_en <= 1'b0;
          state  <= UPDATE;
        end
        UPDATE: begin
          if (upd_fire) begin
            out_valid <= 1'b1;
            state     <= IDLE;
            if (hit) begin
              status      <= ST_HIT;
              value_out   <= hit_data;
              evicted     <= 1'b0;
              evicted_key <= '0;
              for (int i = 0; i < ENTRIES; i++) begin
                if (valid[i] && (rank[i] < hit_rank)) begin
                  rank[i] <= rank[i] + 1'b1;
                end
              end
              rank[hit_idx] <= '0;
            end else if (!found) begin
              status      <= ST_NOTFOUND;
              value_out   <= '0;
              evicted     <= 1'b0;
              evicted_key <= '0;
            end else begin
              status      <= ST_LOADED;
              value_out   <= fill;
              evicted     <= do_evict;
              evicted_key <= do_evict ? vic_tag : '0;
              if (do_ins) begin
                for (int i = 0; i < ENTRIES; i++) begin
                  if (valid[i] && !(do_evict && (IDX_W'(i) == vic_idx))) begin
                    rank[i] <= rank[i] + 1'b1;
                  end
                end
              end
              if (do_evict) begin
                valid[vic_idx] <= 1'b0;
                rank[vic_idx]  <= '0;
              end
              if (do_ins) begin
                valid[slot] <= 1'b1;
                rank[slot]  <= '0;
              end
              occ <= occ - OCC_W'(do_evict) + OCC_W'(do_ins);
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/lru_chk.sv]
module lru_chk #(
  parameter int TAG_BITS   = lru_pkg::TAG_BITS_DEF,
  parameter int VALUE_BITS = lru_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            status,
  input logic [VALUE_BITS-1:0] value_out,
  input logic                  evicted,
  input logic [TAG_BITS-1:0]   evicted_key
);
  import lru_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out)
      && $stable(evicted) && $stable(evicted_key))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_notfound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOTFOUND) |-> (value_out == '0) && !evicted)
    else $error("not found result carries data or eviction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_HIT) |-> !evicted)
    else $error("hit reported an eviction");

  a_evict_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> (evicted_key == '0))
    else $error("evicted key set without eviction");

endmodule

bind lru_cache_lookup_fill_top lru_chk #(
  .TAG_BITS(TAG_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_lru_chk (.*);
